FILE: rtl/lru_tile_cache_allocator_unit_assert.svh
// Assertion macros for the tile cache allocator checker.
// No dependencies; taken in by `include where assertions are written.
`ifndef LRU_TILE_CACHE_ALLOCATOR_UNIT_ASSERT_SVH
`define LRU_TILE_CACHE_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define LTCA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define LTCA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ltca_pkg.sv
// Shared constants for the LRU tile cache allocator.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps

package ltca_pkg;

  localparam int ENTRIES = 1024;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 64;
  localparam int OUT_W   = 10;

endpackage

FILE: rtl/lru_tile_cache_allocator_unit.sv
// Fully associative LRU tile-key cache lookup, walked one entry per cycle.
// Depends on ltca_pkg.
`timescale 1ns / 1ps

// Usage
// -----
// A 128-bit tile key (key_high, key_low) is taken when start is high and
// busy is low. The block walks its recency list from the newest entry
// toward the oldest, comparing one stored key per cycle through a single
// read port of the key store, and stops at a match, at the first empty
// entry, or after the oldest entry. On a hit the entry is moved to the
// newest end; on a miss the oldest entry is overwritten with the key and
// becomes the newest. The answer (entry_index, hit) is shown for exactly
// one cycle with done high; it cannot be held off, so the receiver must
// take it then. busy falls in that same cycle, so a new start may be
// given alongside done.
//
// Steps: the key is taken in S_IDLE, then S_WALK visits V entries (1 to
// ENTRIES), one per cycle, set by the single read port shared between the
// key store and the link stores. S_UNLINK and S_RELINK then rewrite the
// list links, one write per link store per cycle; they are skipped when
// the chosen entry is already the newest.
//
// After reset the block rebuilds the list links, one entry per cycle, with
// busy high. Occupancy is kept as a fill count: empty entries always sit at
// the old end of the list in index order, so entry k holds a key exactly
// when k is below the count.

module lru_tile_cache_allocator_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [ltca_pkg::KEY_W-1:0] key_high,
  input  logic [ltca_pkg::KEY_W-1:0] key_low,
  output logic                      done,
  output logic [ltca_pkg::OUT_W-1:0] entry_index,
  output logic                      hit
);

  import ltca_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_UNLINK,
    S_RELINK
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  state_t state;

  // list bookkeeping
  logic [IDX_W-1:0] sweep_idx;
  logic [CNT_W-1:0] fill;
  logic [IDX_W-1:0] oldest;
  logic [IDX_W-1:0] newest;
  logic [IDX_W-1:0] cur;
  logic [IDX_W-1:0] chosen;
  logic             found;
  logic [KEY_W-1:0] q_high;
  logic [KEY_W-1:0] q_low;

  // stores: keys, and the two link directions
  logic [KEY_W-1:0] key_hi_mem [ENTRIES];
  logic [KEY_W-1:0] key_lo_mem [ENTRIES];
  logic [IDX_W-1:0] old_mem    [ENTRIES];
  logic [IDX_W-1:0] rec_mem    [ENTRIES];

  logic [KEY_W-1:0] key_hi_rd;
  logic [KEY_W-1:0] key_lo_rd;
  logic [IDX_W-1:0] old_rd;
  logic [IDX_W-1:0] rec_rd;

  logic [IDX_W-1:0] rd_addr;
  logic             key_we;
  logic             old_we;
  logic [IDX_W-1:0] old_waddr;
  logic [IDX_W-1:0] old_wdata;
  logic             rec_we;
  logic [IDX_W-1:0] rec_waddr;
  logic [IDX_W-1:0] rec_wdata;

  // walk decision, valid in S_WALK where the read data belongs to cur
  logic             cur_valid;
  logic             key_match;
  logic             walk_on;
  logic             pick_hit;
  logic [IDX_W-1:0] pick;

  assign busy      = (state != S_IDLE);
  assign cur_valid = CNT_W'(cur) < fill;
  assign key_match = (key_hi_rd == q_high) && (key_lo_rd == q_low);
  assign pick_hit  = cur_valid && key_match;
  assign walk_on   = cur_valid && !key_match && (cur != oldest);
  assign pick      = pick_hit ? cur : oldest;

  always_comb begin
    rd_addr   = cur;
    key_we    = 1'b0;
    old_we    = 1'b0;
    old_waddr = sweep_idx;
    old_wdata = '0;
    rec_we    = 1'b0;
    rec_waddr = sweep_idx;
    rec_wdata = '0;
    case (state)
      S_CLEAR: begin
        old_we    = 1'b1;
        old_wdata = (sweep_idx == '0) ? LAST_IDX : sweep_idx - IDX_W'(1);
        rec_we    = 1'b1;
        rec_wdata = (sweep_idx == LAST_IDX) ? '0 : sweep_idx + IDX_W'(1);
      end
      S_IDLE: begin
        rd_addr = newest;
      end
      S_WALK: begin
        if (walk_on) begin
          rd_addr = old_rd;
        end else begin
          // fetch the links of the chosen entry for the unlink step
          rd_addr = pick;
          key_we  = !pick_hit;
        end
      end
      S_UNLINK: begin
        if (chosen != oldest) begin
          rec_we    = 1'b1;
          rec_waddr = old_rd;
          rec_wdata = rec_rd;
          old_we    = 1'b1;
          old_waddr = rec_rd;
          old_wdata = old_rd;
        end
      end
      S_RELINK: begin
        old_we    = 1'b1;
        old_waddr = chosen;
        old_wdata = newest;
        rec_we    = 1'b1;
        rec_waddr = newest;
        rec_wdata = chosen;
      end
      default: begin
        rd_addr = cur;
      end
    endcase
  end

  // storage: one write and one registered read per store per cycle
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_hi_mem[oldest] <= q_high;
      key_lo_mem[oldest] <= q_low;
    end
    if (old_we) begin
      old_mem[old_waddr] <= old_wdata;
    end
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
    key_hi_rd <= key_hi_mem[rd_addr];
    key_lo_rd <= key_lo_mem[rd_addr];
    old_rd    <= old_mem[rd_addr];
    rec_rd    <= rec_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      sweep_idx <= '0;
      fill      <= '0;
      oldest    <= '0;
      newest    <= LAST_IDX;
      cur       <= '0;
      chosen    <= '0;
      found     <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          sweep_idx <= sweep_idx + IDX_W'(1);
          if (sweep_idx == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            q_high <= key_high;
            q_low  <= key_low;
            cur    <= newest;
            state  <= S_WALK;
          end
        end
        S_WALK: begin
          if (walk_on) begin
            cur <= old_rd;
          end else begin
            chosen <= pick;
            found  <= pick_hit;
            if (!pick_hit && (fill < CNT_W'(ENTRIES))) begin
              fill <= fill + CNT_W'(1);
            end
            if (pick == newest) begin
              // already most recent: list stays as it is
              done        <= 1'b1;
              entry_index <= OUT_W'(pick);
              hit         <= pick_hit;
              state       <= S_IDLE;
            end else begin
              state <= S_UNLINK;
            end
          end
        end
        S_UNLINK: begin
          if (chosen == oldest) begin
            oldest <= rec_rd;
          end
          state <= S_RELINK;
        end
        S_RELINK: begin
          newest      <= chosen;
          done        <= 1'b1;
          entry_index <= OUT_W'(chosen);
          hit         <= found;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/ltca_checker.sv
// Port-level checker for the tile cache allocator, bound to the top level.
// Depends on ltca_pkg and lru_tile_cache_allocator_unit_assert.svh.
`timescale 1ns / 1ps
`include "lru_tile_cache_allocator_unit_assert.svh"

module ltca_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic [ltca_pkg::KEY_W-1:0] key_high,
  input logic [ltca_pkg::KEY_W-1:0] key_low,
  input logic                       done,
  input logic [ltca_pkg::OUT_W-1:0] entry_index,
  input logic                       hit
);

  import ltca_pkg::*;

  logic               accepted;
  logic [2*KEY_W-1:0] key_bits;
  logic [OUT_W:0]     res_bits;

  assign accepted = start && !busy;
  assign key_bits = {key_high, key_low};
  assign res_bits = {hit, entry_index};

  // an accepted item keeps the block busy in the cycle after it is taken
  `LTCA_ASSERT_NEXT(a_accept_busy, accepted, busy, "item taken but block not busy")

  // the result comes as the block frees up, never while it still works
  `LTCA_ASSERT_NOW(a_done_idle, done, !busy && $past(busy), "done outside end of item")

  // one strobe per item: done drops again in the cycle after it rises
  `LTCA_ASSERT_NEXT(a_done_single, done, !done, "result strobe held for two cycles")

  // result fields are fully defined while the strobe is up
  `LTCA_ASSERT_NOW(a_done_known, done, !$isunknown(res_bits), "result fields unknown at strobe")

  // key words are fully defined when an item is taken
  `LTCA_ASSERT_NOW(a_key_known, accepted, !$isunknown(key_bits), "key unknown at accept")

endmodule

bind lru_tile_cache_allocator_unit ltca_checker u_ltca_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .key_high    (key_high),
  .key_low     (key_low),
  .done        (done),
  .entry_index (entry_index),
  .hit         (hit)
);

FILE: verif/lru_tile_cache_allocator_unit_tb.sv
// Self-checking bench for the LRU tile cache allocator: directed table, then random lookups.
// Depends on ltca_pkg and lru_tile_cache_allocator_unit; keeps its own recency-list model.
`timescale 1ns / 1ps

module lru_tile_cache_allocator_unit_tb;
  import ltca_pkg::*;

  localparam logic [KEY_W-1:0] ONES     = '1;
  localparam logic [KEY_W-1:0] TOP_BIT  = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic [KEY_W-1:0] CHECKER  = {(KEY_W/2){2'b01}};
  localparam int WATCHDOG_LIMIT = 8000;   // list rebuild or full walk plus a long gap, many times
  localparam int DRAIN_CYCLES   = 16;
  localparam int RANDOM_ITEMS   = 565;
  localparam int HISTORY_DEPTH  = 2048;

  typedef struct packed {
    logic [KEY_W-1:0] hi;
    logic [KEY_W-1:0] lo;
  } key_pair_t;

  typedef struct packed {
    logic [OUT_W-1:0] entry_index;
    logic             hit;
  } alloc_t;

  typedef struct packed {
    logic [KEY_W-1:0] hi;
    logic [KEY_W-1:0] lo;
    logic             typed;       // expected result written below, else from the model
    logic [OUT_W-1:0] entry_index;
    logic             hit;
  } lookup_row_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             start;
  logic             busy;
  logic [KEY_W-1:0] key_high;
  logic [KEY_W-1:0] key_low;
  logic             done;
  logic [OUT_W-1:0] entry_index;
  logic             hit;

  always #5 clk = ~clk;

  lru_tile_cache_allocator_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .key_high    (key_high),
    .key_low     (key_low),
    .done        (done),
    .entry_index (entry_index),
    .hit         (hit)
  );

  // ---------------------------------------------------------------------------
  // Recency-list model. Head is the newest entry, tail the oldest; misses fill
  // empty entries first, then reuse the tail once the store is full.
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0] cached_hi  [ENTRIES];
  logic [KEY_W-1:0] cached_lo  [ENTRIES];
  logic             slot_used  [ENTRIES];
  logic [IDX_W-1:0] link_newer [ENTRIES];
  logic [IDX_W-1:0] link_older [ENTRIES];
  logic [IDX_W-1:0] lru_head;
  logic [IDX_W-1:0] lru_tail;
  int               cache_fill;

  alloc_t    awaited_allocs [$];   // expected results, oldest first
  key_pair_t issued_keys [$];      // keys sent so far, for re-requests
  int        mismatch_count;
  int        burst_left;
  int        quiet_cycles;

  function automatic void clear_model();
    for (int k = 0; k < ENTRIES; k++) begin
      cached_hi[k]  = '0;
      cached_lo[k]  = '0;
      slot_used[k]  = 1'b0;
      link_newer[k] = IDX_W'((k + 1) % ENTRIES);
      link_older[k] = IDX_W'((k + ENTRIES - 1) % ENTRIES);
    end
    lru_tail       = '0;
    lru_head       = IDX_W'(ENTRIES - 1);
    cache_fill     = 0;
  endfunction

  function automatic alloc_t predict_allocation(input logic [KEY_W-1:0] kh,
                                                input logic [KEY_W-1:0] kl);
    logic [IDX_W-1:0] cur;
    logic [IDX_W-1:0] pick;
    logic [IDX_W-1:0] older;
    logic [IDX_W-1:0] newer;
    logic             found;
    alloc_t           res;
    found = 1'b0;
    cur   = lru_head;
    // Walk newest to oldest; stop at an empty entry, a match or the tail.
    for (int s = 0; s < ENTRIES; s++) begin
      if (!slot_used[cur]) break;
      if (cached_hi[cur] == kh && cached_lo[cur] == kl) begin
        found = 1'b1;
        break;
      end
      if (cur == lru_tail) break;
      cur = link_older[cur];
    end
    if (found) begin
      pick = cur;
    end else begin
      pick = lru_tail;
      if (cache_fill < ENTRIES) cache_fill++;
      cached_hi[pick] = kh;
      cached_lo[pick] = kl;
      slot_used[pick] = 1'b1;
    end
    // Move to the newest end; a hit on the head leaves the list alone.
    if (pick != lru_head) begin
      if (pick == lru_tail) begin
        lru_tail = link_newer[pick];
      end else begin
        older = link_older[pick];
        newer = link_newer[pick];
        link_newer[older] = newer;
        link_older[newer] = older;
      end
      link_older[pick]     = lru_head;
      link_newer[lru_head] = pick;
      lru_head             = pick;
    end
    res.entry_index = OUT_W'(pick);
    res.hit         = found;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: done marks a single-cycle result, taken at the closing edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    alloc_t want;
    if (!rst && done !== 1'b0) begin
      if (awaited_allocs.size() == 0) begin
        report_mismatch($sformatf("unexpected result index %0d hit %b", entry_index, hit));
      end else begin
        want = awaited_allocs.pop_front();
        if (entry_index !== want.entry_index)
          report_mismatch($sformatf("entry_index %0d, wanted %0d",
                                    entry_index, want.entry_index));
        if (hit !== want.hit)
          report_mismatch($sformatf("hit %b, wanted %b", hit, want.hit));
      end
    end
  end

  // Watchdog: any accepted item or result resets the count.
  always @(posedge clk) begin
    if (rst || (start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: bursts of back-to-back items with random gaps between them.
  // ---------------------------------------------------------------------------
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drive one item and hold it until taken; a typed row overrides the model's answer.
  task automatic issue_lookup(input lookup_row_t row);
    alloc_t    predicted;
    key_pair_t kp;
    start    <= 1'b1;
    key_high <= row.hi;
    key_low  <= row.lo;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    predicted = predict_allocation(row.hi, row.lo);
    if (row.typed) begin
      predicted.entry_index = row.entry_index;
      predicted.hit         = row.hit;
    end
    awaited_allocs.push_back(predicted);
    kp.hi = row.hi;
    kp.lo = row.lo;
    issued_keys.push_back(kp);
    if (issued_keys.size() > HISTORY_DEPTH) void'(issued_keys.pop_front());
    pace_sender();
  endtask

  function automatic logic [KEY_W-1:0] fresh_word();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return ONES;
      2:       return TOP_BIT >> $urandom_range(0, KEY_W - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mix of new keys, recent re-requests, deep re-requests and one-bit near misses.
  // While the store is filling, new keys dominate.
  function automatic key_pair_t choose_key();
    key_pair_t kp;
    int        roll;
    int        depth;
    int        bitpos;
    roll = $urandom_range(0, 99);
    if (cache_fill < ENTRIES) roll = (roll < 75) ? 0 : roll;
    else                      roll = (roll < 40) ? 0 : roll;
    if (roll == 0 || issued_keys.size() == 0) begin
      kp.hi = fresh_word();
      kp.lo = fresh_word();
    end else if (roll < 85) begin
      depth = (issued_keys.size() < 8) ? issued_keys.size() : 8;
      kp = issued_keys[issued_keys.size() - 1 - $urandom_range(0, depth - 1)];
    end else if (roll < 95) begin
      kp = issued_keys[$urandom_range(0, issued_keys.size() - 1)];
    end else begin
      kp = issued_keys[$urandom_range(0, issued_keys.size() - 1)];
      bitpos = $urandom_range(0, KEY_W - 1);
      if ($urandom_range(0, 1)) kp.hi[bitpos] = ~kp.hi[bitpos];
      else                      kp.lo[bitpos] = ~kp.lo[bitpos];
    end
    return kp;
  endfunction

  // Directed table. After reset misses fill entries in index order, so the
  // first rows can be read straight off: zero key, all-ones key, hit on an
  // older entry, hit on the newest, keys differing only in one word.
  localparam int DIRECTED_ROWS = 15;
  lookup_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'0,          '0,          1'b1, 10'd0, 1'b0},
    '{ONES,        ONES,        1'b1, 10'd1, 1'b0},
    '{'0,          '0,          1'b1, 10'd0, 1'b1},
    '{'0,          '0,          1'b1, 10'd0, 1'b1},
    '{64'd1,       '0,          1'b1, 10'd2, 1'b0},
    '{'0,          64'd1,       1'b1, 10'd3, 1'b0},
    '{ONES,        ONES - 1,    1'b1, 10'd4, 1'b0},
    '{ONES,        ONES,        1'b1, 10'd1, 1'b1},
    '{TOP_BIT,     '0,          1'b0, 10'd0, 1'b0},
    '{'0,          TOP_BIT,     1'b0, 10'd0, 1'b0},
    '{'0,          '0,          1'b0, 10'd0, 1'b0},   // deepest valid entry
    '{CHECKER,     ~CHECKER,    1'b0, 10'd0, 1'b0},
    '{~CHECKER,    CHECKER,     1'b0, 10'd0, 1'b0},
    '{64'd1,       '0,          1'b0, 10'd0, 1'b0},
    '{ONES - 1,    ONES,        1'b0, 10'd0, 1'b0}
  };

  initial begin : stimulus
    lookup_row_t row;
    key_pair_t   kp;
    int          random_items;
    rst            = 1'b1;
    start          = 1'b0;
    key_high       = '0;
    key_low        = '0;
    mismatch_count = 0;
    burst_left     = 0;
    quiet_cycles   = 0;
    random_items   = 0;
    clear_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) issue_lookup(directed_rows[i]);

    // Random part: a fixed number of lookups checked against the model.
    while (random_items < RANDOM_ITEMS) begin
      kp    = choose_key();
      row   = '0;
      row.hi = kp.hi;
      row.lo = kp.lo;
      issue_lookup(row);
      random_items++;
    end

    start <= 1'b0;
    while (awaited_allocs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
